// ===== hw/rtl/lin_frame_receiver_unit_assert.svh =====
// Assertion macros for the LIN frame receiver checker.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef LIN_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define LIN_FRAME_RECEIVER_UNIT_ASSERT_SVH

// Same-cycle implication, masked while reset is high
`define LFR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lin frame receiver: check failed");

// Next-cycle implication, masked while reset is high
`define LFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lin frame receiver: check failed");

// Next-cycle implication that is also checked across reset
`define LFR_ASSERT_NEXT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("lin frame receiver: check failed");

`endif

// ===== hw/rtl/lfr_pkg.sv =====
// Package for the LIN frame receiver: field widths, register indexes, frame table packing,
// event and result codes and the receive phase type. No dependencies.
package lfr_pkg;

  localparam int BYTE_W      = 8;
  localparam int ENTRY_W     = 13;
  localparam int LEN_W       = 4;
  localparam int POS_W       = 4;
  localparam int IDX_W       = 2;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = ENTRY_W;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_RX_ENABLE     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_ENTRY_0 = 3'd1;
  localparam int                     CFG_ENTRY_REGS    = 4;

  // Frame table entry packing
  localparam int ENTRY_PID_LSB = 0;
  localparam int ENTRY_LEN_LSB = 8;
  localparam int ENTRY_ENH_BIT = 12;

  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h55;
  localparam logic [BYTE_W-1:0] BYTE_MASK = 8'hFF;

  // Input event codes
  localparam logic REQ_BYTE  = 1'b0;
  localparam logic REQ_BREAK = 1'b1;

  // Result kinds
  localparam logic KIND_STORED  = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_SYNC = 3'd1,
    PH_PID  = 3'd2,
    PH_DATA = 3'd3,
    PH_CS   = 3'd4
  } rx_phase_t;

endpackage

// ===== hw/rtl/lfr_event_if.sv =====
// Valid/ready stream interfaces for line events in and frame results out.
// Depends on lfr_pkg for field widths.
interface lfr_event_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [lfr_pkg::BYTE_W-1:0]  rx_byte;

  modport source (output valid, req_type, rx_byte, input ready);
  modport sink   (input valid, req_type, rx_byte, output ready);
endinterface

interface lfr_result_if;
  logic                        valid;
  logic                        ready;
  logic                        result_kind;
  logic [lfr_pkg::IDX_W-1:0]   entry_index;
  logic [lfr_pkg::POS_W-1:0]   byte_position;
  logic [lfr_pkg::BYTE_W-1:0]  byte_value;
  logic                        data_complete;
  logic                        checksum_ok;

  modport source (output valid, result_kind, entry_index, byte_position, byte_value,
                  data_complete, checksum_ok, input ready);
  modport sink   (input valid, result_kind, entry_index, byte_position, byte_value,
                  data_complete, checksum_ok, output ready);
endinterface

// ===== hw/rtl/lin_frame_receiver_unit.sv =====
// LIN frame receiver top level: phase tracking, PID match, checksum check,
// output register with skid stage. Depends on lfr_pkg and lfr_event_if.sv.
//
//  channel  | dir | transaction            | payload
//  ---------+-----+------------------------+----------------------------------------
//  rx       | in  | one break or byte      | req_type, rx_byte
//  res      | out | stored byte or verdict | result_kind, entry_index, byte_position,
//           |     |                        | byte_value, data_complete, checksum_ok
//  cfg_*    | in  | register write         | cfg_index, cfg_wdata
//
// One event is taken per cycle while rx.ready is high; its result is offered at res from the output register.
// The phase, sum and count registers update in the cycle the event is taken.
// A result stalled at res is held while a second result fills the skid stage;
// rx.ready drops only while both are full. Reset is synchronous and clears
// all phase state, configuration registers and the output valid flags.
module lin_frame_receiver_unit #(
  parameter int TABLE_ENTRIES  = 4,
  parameter int MAX_DATA_BYTES = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  lfr_event_if.sink                           rx,
  lfr_result_if.source                        res,
  input  logic                                cfg_we,
  input  logic [lfr_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [lfr_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  typedef struct packed {
    logic                        result_kind;
    logic [lfr_pkg::IDX_W-1:0]   entry_index;
    logic [lfr_pkg::POS_W-1:0]   byte_position;
    logic [lfr_pkg::BYTE_W-1:0]  byte_value;
    logic                        data_complete;
    logic                        checksum_ok;
  } result_t;

  localparam logic [lfr_pkg::LEN_W-1:0] MAX_LEN = lfr_pkg::LEN_W'(MAX_DATA_BYTES);

  // Configuration registers
  logic                             rx_enable;
  logic [lfr_pkg::ENTRY_W-1:0]      frame_entry [TABLE_ENTRIES];

  // Frame state
  lfr_pkg::rx_phase_t               rx_phase, rx_phase_next;
  logic [lfr_pkg::IDX_W-1:0]        matched_entry, matched_entry_next;
  logic [lfr_pkg::POS_W-1:0]        byte_count, byte_count_next;
  logic [lfr_pkg::BYTE_W-1:0]       running_sum, running_sum_next;

  // Output register and skid stage
  logic                             out_valid, skid_valid;
  result_t                          out_data, skid_data;

  logic                             accept;
  logic                             new_valid;
  result_t                          new_data;

  // PID match and length lookup
  logic                             pid_hit;
  logic [lfr_pkg::IDX_W-1:0]        pid_idx;
  logic                             pid_enh;
  logic [lfr_pkg::ENTRY_W-1:0]      cur_entry;
  logic [lfr_pkg::LEN_W-1:0]        raw_len, frame_len;
  logic [lfr_pkg::BYTE_W+1-1:0]     sum_wide;
  logic [lfr_pkg::BYTE_W-1:0]       sum_fold;

  assign accept   = rx.valid && rx.ready;
  assign rx.ready = !skid_valid;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_enable <= 1'b0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        frame_entry[i] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == lfr_pkg::CFG_RX_ENABLE) begin
        rx_enable <= cfg_wdata[0];
      end
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (i < lfr_pkg::CFG_ENTRY_REGS &&
            cfg_index == lfr_pkg::CFG_INDEX_W'(int'(lfr_pkg::CFG_FRAME_ENTRY_0) + i)) begin
          frame_entry[i] <= cfg_wdata;
        end
      end
    end
  end

  // Find the lowest entry whose PID matches the received byte
  always_comb begin
    pid_hit = 1'b0;
    pid_idx = '0;
    pid_enh = 1'b0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (frame_entry[i][lfr_pkg::ENTRY_PID_LSB +: lfr_pkg::BYTE_W] == rx.rx_byte) begin
        pid_hit = 1'b1;
        pid_idx = lfr_pkg::IDX_W'(i);
        pid_enh = frame_entry[i][lfr_pkg::ENTRY_ENH_BIT];
      end
    end
  end

  // Select the matched entry for the data length; slots past the table read as zero
  always_comb begin
    cur_entry = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (i < (1 << lfr_pkg::IDX_W) && matched_entry == lfr_pkg::IDX_W'(i)) begin
        cur_entry = frame_entry[i];
      end
    end
    raw_len = cur_entry[lfr_pkg::ENTRY_LEN_LSB +: lfr_pkg::LEN_W];
    if (raw_len == '0) begin
      frame_len = lfr_pkg::LEN_W'(1);
    end else if (raw_len > MAX_LEN) begin
      frame_len = MAX_LEN;
    end else begin
      frame_len = raw_len;
    end
  end

  // End-around-carry add of the received byte
  assign sum_wide = {1'b0, running_sum} + {1'b0, rx.rx_byte};
  assign sum_fold = sum_wide[lfr_pkg::BYTE_W-1:0] +
                    lfr_pkg::BYTE_W'(sum_wide[lfr_pkg::BYTE_W]);

  // Next phase and result for the event at the input
  always_comb begin
    rx_phase_next      = rx_phase;
    matched_entry_next = matched_entry;
    byte_count_next    = byte_count;
    running_sum_next   = running_sum;
    new_valid          = 1'b0;
    new_data           = '0;
    new_data.entry_index = matched_entry;

    if (accept && rx_enable) begin
      if (rx.req_type == lfr_pkg::REQ_BREAK) begin
        if (rx_phase == lfr_pkg::PH_IDLE) begin
          matched_entry_next = '0;
          byte_count_next    = '0;
          running_sum_next   = '0;
          rx_phase_next      = lfr_pkg::PH_SYNC;
        end
      end else begin
        case (rx_phase)
          lfr_pkg::PH_SYNC: begin
            if (rx.rx_byte == lfr_pkg::SYNC_BYTE) begin
              rx_phase_next = lfr_pkg::PH_PID;
            end
          end
          lfr_pkg::PH_PID: begin
            if (pid_hit) begin
              matched_entry_next     = pid_idx;
              byte_count_next        = '0;
              running_sum_next       = pid_enh ? rx.rx_byte : '0;
              rx_phase_next          = lfr_pkg::PH_DATA;
              new_valid              = 1'b1;
              new_data.result_kind   = lfr_pkg::KIND_STORED;
              new_data.entry_index   = pid_idx;
              new_data.byte_position = '0;
              new_data.byte_value    = rx.rx_byte;
            end
          end
          lfr_pkg::PH_DATA: begin
            byte_count_next        = byte_count + lfr_pkg::POS_W'(1);
            running_sum_next       = sum_fold;
            new_valid              = 1'b1;
            new_data.result_kind   = lfr_pkg::KIND_STORED;
            new_data.byte_position = byte_count_next;
            new_data.byte_value    = rx.rx_byte;
            new_data.data_complete = (byte_count_next >= frame_len);
            if (byte_count_next >= frame_len) begin
              rx_phase_next = lfr_pkg::PH_CS;
            end
          end
          lfr_pkg::PH_CS: begin
            rx_phase_next        = lfr_pkg::PH_IDLE;
            new_valid            = 1'b1;
            new_data.result_kind = lfr_pkg::KIND_VERDICT;
            new_data.byte_value  = rx.rx_byte;
            new_data.checksum_ok = ((~running_sum & lfr_pkg::BYTE_MASK) == rx.rx_byte);
          end
          default: begin
            rx_phase_next = rx_phase;
          end
        endcase
      end
    end
  end

  // Hold frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_phase      <= lfr_pkg::PH_IDLE;
      matched_entry <= '0;
      byte_count    <= '0;
      running_sum   <= '0;
    end else begin
      rx_phase      <= rx_phase_next;
      matched_entry <= matched_entry_next;
      byte_count    <= byte_count_next;
      running_sum   <= running_sum_next;
    end
  end

  // Advance results through the output register and skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (res.ready) begin
        skid_valid <= 1'b0;
      end
    end else if (new_valid) begin
      if (!out_valid || res.ready) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (res.ready) begin
        out_data <= skid_data;
      end
    end else if (new_valid) begin
      if (!out_valid || res.ready) begin
        out_data <= new_data;
      end else begin
        skid_data <= new_data;
      end
    end
  end

  assign res.valid         = out_valid;
  assign res.result_kind   = out_data.result_kind;
  assign res.entry_index   = out_data.entry_index;
  assign res.byte_position = out_data.byte_position;
  assign res.byte_value    = out_data.byte_value;
  assign res.data_complete = out_data.data_complete;
  assign res.checksum_ok   = out_data.checksum_ok;

endmodule

// ===== hw/rtl/lfr_checker.sv =====
// Port-level checks for the LIN frame receiver, bound to its top level.
// Depends on lin_frame_receiver_unit_assert.svh.
`include "lin_frame_receiver_unit_assert.svh"

module lfr_checker (
  input logic clk,
  input logic rst,
  input logic rx_ready,
  input logic res_valid,
  input logic res_ready
);

  // A stalled result stays offered
  `LFR_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid)

  // Nothing is offered right after reset
  `LFR_ASSERT_NEXT_ALWAYS(a_res_reset, rst, !res_valid)

  // Input backpressure only with a result waiting at the output
  `LFR_ASSERT_NOW(a_ready_needs_out, !rx_ready, res_valid)

  // A full skid stage with a stalled output stays full
  `LFR_ASSERT_NEXT(a_skid_hold, !rx_ready && !res_ready, !rx_ready)

endmodule

bind lin_frame_receiver_unit lfr_checker u_lfr_checker (
  .clk       (clk),
  .rst       (rst),
  .rx_ready  (rx.ready),
  .res_valid (res.valid),
  .res_ready (res.ready)
);
